// ===== rtl/core/dspm_pkg.sv =====
// ----------------------------------------------------------------------------
// Drum sample player package
// Sizes, item kinds, control word layout and the sequencer's microcode.
// ----------------------------------------------------------------------------
`default_nettype none

package dspm_pkg;

   localparam int VOICES      = 8;
   localparam int MAX_LEN     = 4096;
   localparam int SAMPLE_BITS = 16;

   localparam int VOICE_W     = 3;
   localparam int NOTE_W      = 7;
   localparam int ADDR_W      = $clog2(MAX_LEN);
   localparam int LEN_W       = ADDR_W + 1;
   localparam int MIX_W       = 19;
   localparam int STORE_DEPTH = VOICES * MAX_LEN;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int EXT_W       = MIX_W - SAMPLE_BITS;
   localparam int STEP_W      = 3;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_NOTE  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_SET   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_CLEAR = 3'd1,
      OP_VOICE = 3'd2,
      OP_OUT   = 3'd3,
      OP_NOTE  = 3'd4,
      OP_WRITE = 3'd5,
      OP_SET   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      CND_GOTO     = 2'd0,
      CND_DISPATCH = 2'd1,
      CND_LOOP     = 2'd2,
      CND_OUT      = 2'd3
   } cond_type;

   typedef struct packed {
      logic              ready;
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic last_voice;
      logic out_free;
   } status_type;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 3'd1;
   localparam logic [STEP_W-1:0] STEP_VOICE = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd3;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_NOTE  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_WRITE = 3'd6;
   localparam logic [STEP_W-1:0] STEP_SET   = 3'd7;

   // The control store: one word per step.
   function automatic ctrl_type microcode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{ready: 1'b0, op: OP_NONE, cond: CND_GOTO, target: STEP_IDLE};
      case (step)
         STEP_IDLE:  w = '{ready: 1'b1, op: OP_NONE,  cond: CND_DISPATCH,
                           target: STEP_IDLE};
         STEP_CLEAR: w = '{ready: 1'b0, op: OP_CLEAR, cond: CND_GOTO,
                           target: STEP_VOICE};
         STEP_VOICE: w = '{ready: 1'b0, op: OP_VOICE, cond: CND_LOOP,
                           target: STEP_DRAIN};
         STEP_DRAIN: w = '{ready: 1'b0, op: OP_NONE,  cond: CND_GOTO,
                           target: STEP_OUT};
         STEP_OUT:   w = '{ready: 1'b0, op: OP_OUT,   cond: CND_OUT,
                           target: STEP_IDLE};
         STEP_NOTE:  w = '{ready: 1'b0, op: OP_NOTE,  cond: CND_GOTO,
                           target: STEP_IDLE};
         STEP_WRITE: w = '{ready: 1'b0, op: OP_WRITE, cond: CND_GOTO,
                           target: STEP_IDLE};
         STEP_SET:   w = '{ready: 1'b0, op: OP_SET,   cond: CND_GOTO,
                           target: STEP_IDLE};
         default:    w = '{ready: 1'b0, op: OP_NONE,  cond: CND_GOTO,
                           target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // Entry step of the routine for each kind of transaction.
   function automatic logic [STEP_W-1:0] dispatch(input kind_type kind);
      logic [STEP_W-1:0] s;
      case (kind)
         KIND_TICK:  s = STEP_CLEAR;
         KIND_NOTE:  s = STEP_NOTE;
         KIND_WRITE: s = STEP_WRITE;
         KIND_SET:   s = STEP_SET;
         default:    s = STEP_IDLE;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dspm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dspm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/dspm_seq.sv =====
// ----------------------------------------------------------------------------
// Drum sample player sequencer
// Step counter over the control store, with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module dspm_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [1:0]           kind,
   input  wire dspm_pkg::status_type status,
   output dspm_pkg::ctrl_type        ctrl
);

   logic [dspm_pkg::STEP_W-1:0] step_ff;
   logic [dspm_pkg::STEP_W-1:0] step_in;

   assign ctrl = dspm_pkg::microcode(step_ff);

   always_comb begin
      step_in = step_ff;
      case (ctrl.cond)
         dspm_pkg::CND_GOTO: begin
            step_in = ctrl.target;
         end
         dspm_pkg::CND_DISPATCH: begin
            if (accept) begin
               step_in = dspm_pkg::dispatch(dspm_pkg::kind_type'(kind));
            end
         end
         dspm_pkg::CND_LOOP: begin
            if (status.last_voice) begin
               step_in = ctrl.target;
            end
         end
         dspm_pkg::CND_OUT: begin
            if (status.out_free) begin
               step_in = ctrl.target;
            end
         end
         default: begin
            step_in = dspm_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dspm_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dspm_datapath.sv =====
// ----------------------------------------------------------------------------
// Drum sample player datapath
// Voice slot registers, sample store, mix accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dspm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dspm_pkg::ctrl_type                  ctrl,
   input  wire logic                                accept,
   input  wire logic [dspm_pkg::NOTE_W-1:0]         in_note,
   input  wire logic [dspm_pkg::VOICE_W-1:0]        in_voice,
   input  wire logic [11:0]                         in_addr,
   input  wire logic signed [15:0]                  in_sample,
   input  wire logic [12:0]                         in_length,
   output dspm_pkg::status_type                     status,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic signed [dspm_pkg::MIX_W-1:0]        out_mix
);

   // Latched transaction fields.
   logic [dspm_pkg::NOTE_W-1:0]      note_ff;
   logic [dspm_pkg::VOICE_W-1:0]     voice_ff;
   logic [dspm_pkg::ADDR_W-1:0]      addr_ff;
   logic [dspm_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [dspm_pkg::LEN_W-1:0]       length_ff;

   logic [dspm_pkg::NOTE_W-1:0]  slot_note_ff    [dspm_pkg::VOICES];
   logic [dspm_pkg::NOTE_W-1:0]  slot_note_in    [dspm_pkg::VOICES];
   logic [dspm_pkg::LEN_W-1:0]   slot_len_ff     [dspm_pkg::VOICES];
   logic [dspm_pkg::LEN_W-1:0]   slot_len_in     [dspm_pkg::VOICES];
   logic [dspm_pkg::LEN_W-1:0]   pos_ff          [dspm_pkg::VOICES];
   logic [dspm_pkg::LEN_W-1:0]   pos_in          [dspm_pkg::VOICES];
   logic [dspm_pkg::VOICES-1:0]  playing_ff;
   logic [dspm_pkg::VOICES-1:0]  playing_in;

   logic [dspm_pkg::VOICE_W-1:0] vcnt_ff;
   logic [dspm_pkg::VOICE_W-1:0] vcnt_in;
   logic                         add_ff;
   logic                         add_in;
   logic signed [dspm_pkg::MIX_W-1:0] acc_ff;
   logic signed [dspm_pkg::MIX_W-1:0] acc_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [dspm_pkg::MIX_W-1:0] rsp_mix_ff;

   logic [dspm_pkg::LEN_W-1:0]       cur_pos;
   logic [dspm_pkg::LEN_W-1:0]       cur_len;
   logic [dspm_pkg::LEN_W-1:0]       next_pos;
   logic [dspm_pkg::VOICES-1:0]      match;
   logic [dspm_pkg::VOICE_W-1:0]     hit_idx;
   logic                             hit;
   logic                             voice_ok;
   logic                             ram_we;
   logic [dspm_pkg::STORE_AW-1:0]    ram_waddr;
   logic [dspm_pkg::STORE_AW-1:0]    ram_raddr;
   logic [dspm_pkg::SAMPLE_BITS-1:0] ram_rdata;
   logic signed [dspm_pkg::MIX_W-1:0] rd_ext;

   always_ff @(posedge clock) begin
      if (accept) begin
         note_ff   <= in_note;
         voice_ff  <= in_voice;
         addr_ff   <= dspm_pkg::ADDR_W'(in_addr);
         sample_ff <= dspm_pkg::SAMPLE_BITS'(in_sample);
         // Lengths beyond the slot capacity saturate.
         if (int'(in_length) > dspm_pkg::MAX_LEN) begin
            length_ff <= dspm_pkg::LEN_W'(dspm_pkg::MAX_LEN);
         end else begin
            length_ff <= dspm_pkg::LEN_W'(in_length);
         end
      end
   end

   assign voice_ok = int'(voice_ff) < dspm_pkg::VOICES;
   assign cur_pos  = pos_ff[vcnt_ff];
   assign cur_len  = slot_len_ff[vcnt_ff];
   assign next_pos = cur_pos + 1'b1;

   // Lowest enabled slot whose tag equals the note.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < dspm_pkg::VOICES; i++) begin
         match[i] = (slot_len_ff[i] != '0) && (slot_note_ff[i] == note_ff);
      end
      for (int i = dspm_pkg::VOICES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = dspm_pkg::VOICE_W'(i);
         end
      end
   end

   always_comb begin
      slot_note_in = slot_note_ff;
      slot_len_in  = slot_len_ff;
      pos_in       = pos_ff;
      playing_in   = playing_ff;
      vcnt_in      = vcnt_ff;
      add_in       = 1'b0;
      acc_in       = add_ff ? acc_ff + rd_ext : acc_ff;
      case (ctrl.op)
         dspm_pkg::OP_CLEAR: begin
            acc_in  = '0;
            vcnt_in = '0;
         end
         dspm_pkg::OP_VOICE: begin
            vcnt_in = vcnt_ff + 1'b1;
            if (playing_ff[vcnt_ff]) begin
               add_in          = cur_pos < cur_len;
               pos_in[vcnt_ff] = next_pos;
               if (next_pos >= cur_len) begin
                  playing_in[vcnt_ff] = 1'b0;
               end
            end
         end
         dspm_pkg::OP_NOTE: begin
            if (hit) begin
               pos_in[hit_idx]     = '0;
               playing_in[hit_idx] = 1'b1;
            end
         end
         dspm_pkg::OP_SET: begin
            if (voice_ok) begin
               slot_note_in[voice_ff] = note_ff;
               slot_len_in[voice_ff]  = length_ff;
               pos_in[voice_ff]       = '0;
               playing_in[voice_ff]   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dspm_pkg::VOICES; i++) begin
            slot_note_ff[i] <= '0;
            slot_len_ff[i]  <= '0;
            pos_ff[i]       <= '0;
         end
         playing_ff <= '0;
         vcnt_ff    <= '0;
         add_ff     <= 1'b0;
      end else begin
         slot_note_ff <= slot_note_in;
         slot_len_ff  <= slot_len_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         vcnt_ff      <= vcnt_in;
         add_ff       <= add_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign ram_we    = (ctrl.op == dspm_pkg::OP_WRITE) && voice_ok;
   assign ram_waddr = {voice_ff, addr_ff};
   assign ram_raddr = {vcnt_ff, cur_pos[dspm_pkg::ADDR_W-1:0]};
   assign rd_ext    = {{dspm_pkg::EXT_W{ram_rdata[dspm_pkg::SAMPLE_BITS-1]}}, ram_rdata};

   dspm_ram #(
      .WIDTH (dspm_pkg::SAMPLE_BITS),
      .DEPTH (dspm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (sample_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Result register: it can hold one mix while the next transaction runs.
   assign status.out_free   = !rsp_valid_ff || out_ready;
   assign status.last_voice = vcnt_ff == dspm_pkg::VOICE_W'(dspm_pkg::VOICES - 1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !out_ready;
      if (ctrl.op == dspm_pkg::OP_OUT && status.out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == dspm_pkg::OP_OUT && status.out_free) begin
         rsp_mix_ff <= acc_ff;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_mix   = rsp_mix_ff;

endmodule

`default_nettype wire

// ===== rtl/core/drum_sample_player_mixer.sv =====
// ----------------------------------------------------------------------------
// Drum sample player and mixer
// Eight one-shot voice slots sharing one sample store, mixed on every tick.
// ----------------------------------------------------------------------------
// A tick transaction goes from acceptance through a dispatch step, a clear
// step, the voice step for each voice slot through the single read port of
// the sample store, a drain step for the last registered read and an output
// step that waits for a free output register. Note, sample write and slot set
// transactions each have their own step. One transaction is worked on at a
// time; a finished mix waits in the output register while the next one is
// accepted. Sample words never written read as undefined values.
`default_nettype none

module drum_sample_player_mixer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_kind,
   input  wire logic [6:0]                       req_note,
   input  wire logic [2:0]                       req_voice,
   input  wire logic [11:0]                      req_addr,
   input  wire logic signed [15:0]               req_sample,
   input  wire logic [12:0]                      req_length,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [dspm_pkg::MIX_W-1:0]     rsp_mix
);

   dspm_pkg::ctrl_type   ctrl;
   dspm_pkg::status_type status;
   logic                 accept;

   assign req_ready = ctrl.ready;
   assign accept    = req_valid && req_ready;

   dspm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .status (status),
      .ctrl   (ctrl)
   );

   dspm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .accept    (accept),
      .in_note   (req_note),
      .in_voice  (req_voice),
      .in_addr   (req_addr),
      .in_sample (req_sample),
      .in_length (req_length),
      .status    (status),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_mix   (rsp_mix)
   );

   // Every routine leaves the idle step after a transaction is accepted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input still ready right after a transaction");

   // A new result only appears from the output step.
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(ctrl.op == dspm_pkg::OP_OUT))
      else $error("result loaded outside the output step");

   // The last voice step is followed by the drain step.
   a_voice_loop_end: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == dspm_pkg::OP_VOICE && status.last_voice)
      |=> (ctrl.op == dspm_pkg::OP_NONE && !req_ready))
      else $error("voice loop did not end in the drain step");

endmodule

`default_nettype wire
